// ===== src/random_permutation_shuffle_core_macros.svh =====
// ----------------------------------------------------------------------------
// Shuffle core assertion macros
// Concurrent assertion helpers for the permutation shuffle core.
// ----------------------------------------------------------------------------
`ifndef RANDOM_PERMUTATION_SHUFFLE_CORE_MACROS_SVH
`define RANDOM_PERMUTATION_SHUFFLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define RPS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shuffle core: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define RPS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shuffle core: next-cycle check failed");
`else
`define RPS_ASSERT_IMP(label, clk, rst, ante, cons)
`define RPS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/rps_pkg.sv =====
// ----------------------------------------------------------------------------
// Shuffle core package
// Field widths and parameter defaults for the permutation shuffle core.
// ----------------------------------------------------------------------------
package rps_pkg;

  // Field widths
  localparam int POS_W  = 8;   // position, value and last index
  localparam int RAND_W = 15;  // random word field

  // Parameter defaults
  localparam int MAX_ITEMS_DEF = 256;
  localparam int RAND_BITS_DEF = 15;

endpackage

// ===== src/random_permutation_shuffle_core.sv =====
// ----------------------------------------------------------------------------
// Random permutation shuffle core
// Forward Fisher-Yates shuffle of 0..last_index, one position per request.
// ----------------------------------------------------------------------------
// Each input request carries a random word. At position i the core draws
// n = last_index - i + 1, picks j = i + (word mod n), swaps entries i and j
// of the permutation store and returns position i with its now-final value;
// the result for position last_index carries tlast and the next request
// starts a new run. Only the low RAND_BITS bits of the word are used (all 15
// when RAND_BITS is larger). A request passes from acceptance through the
// restoring remainder unit, one word bit per step, then one memory read and
// two swap writes over the single write port of the permutation memory,
// and only then does the core take the next request. A finished result sits
// in an output register, so the next request is taken while it waits; only a
// result that is still waiting when the following one is done holds the core.
// The permutation values live in a min(MAX_ITEMS, 256) x 8 memory with two
// registered read ports; per-entry written flags sit in flip-flops that are
// cleared together at the start of each run, so there is no clearing pass.
// Write last_index only while the core is idle; a position beyond the new
// value restarts the run at position 0.
`include "random_permutation_shuffle_core_macros.svh"

module random_permutation_shuffle_core
  import rps_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF,
  parameter int RAND_BITS = RAND_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: last_index
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  // input requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [14:0] rand_value, [15] zero
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] position, [15:8] perm_value
  output logic        m_tlast    // run_last
);

  localparam int DEPTH     = (MAX_ITEMS < 256) ? MAX_ITEMS : 256;
  localparam int AW        = $clog2(DEPTH);
  localparam int WORD_BITS = (RAND_BITS < RAND_W) ? RAND_BITS : RAND_W;
  localparam int CW        = $clog2(WORD_BITS + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DIV    = 5'b00010,
    S_READ   = 5'b00100,
    S_SWAP_I = 5'b01000,
    S_SWAP_J = 5'b10000
  } state_t;

  state_t                 state;
  logic [POS_W-1:0]       last_index;
  logic [POS_W-1:0]       step_position;
  logic [POS_W-1:0]       i_pos;
  logic [POS_W-1:0]       last_r;
  logic [POS_W:0]         n_r;
  logic [POS_W-1:0]       rem;
  logic [WORD_BITS-1:0]   word_sh;
  logic [CW-1:0]          cnt;
  logic [DEPTH-1:0]       written;
  logic [POS_W-1:0]       perm_mem [DEPTH];
  logic [POS_W-1:0]       q_i;
  logic [POS_W-1:0]       q_j;
  logic                   f_i;
  logic                   f_j;
  logic [POS_W-1:0]       vi_r;
  logic                   out_valid;
  logic [POS_W-1:0]       out_pos;
  logic [POS_W-1:0]       out_val;
  logic                   out_last;

  logic [POS_W-1:0]       last_eff;
  logic [POS_W-1:0]       i_start;
  logic                   accept;
  logic [POS_W:0]         trial;
  logic                   trial_ge;
  logic [POS_W-1:0]       rem_next;
  logic [POS_W-1:0]       j_pos;
  logic [AW-1:0]          i_addr;
  logic [AW-1:0]          j_addr;
  logic [POS_W-1:0]       vi;
  logic [POS_W-1:0]       vj;
  logic                   out_free;
  logic                   out_load;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [POS_W-1:0]       mem_wdata;

  // Saturate the last index to the store depth; restart a run that is past it.
  assign last_eff = (last_index > POS_W'(DEPTH - 1)) ? POS_W'(DEPTH - 1) : last_index;
  assign i_start  = (step_position > last_eff) ? '0 : step_position;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // One restoring remainder step: shift in the next word bit, subtract n if it fits.
  assign trial    = {rem, word_sh[WORD_BITS-1]};
  assign trial_ge = (trial >= n_r);
  assign rem_next = trial_ge ? POS_W'(trial - n_r) : trial[POS_W-1:0];

  // j never exceeds last_r, so the sum stays in range.
  assign j_pos  = i_pos + rem;
  assign i_addr = i_pos[AW-1:0];
  assign j_addr = j_pos[AW-1:0];

  // An entry not written in this run reads as its own index.
  assign vi = f_i ? q_i : i_pos;
  assign vj = f_j ? q_j : j_pos;

  assign out_free = !out_valid || m_tready;
  assign out_load = (state == S_SWAP_J) && out_free;

  assign mem_we    = (state == S_SWAP_I) || (state == S_SWAP_J);
  assign mem_waddr = (state == S_SWAP_I) ? i_addr : j_addr;
  assign mem_wdata = (state == S_SWAP_I) ? vj : vi_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_index <= '0;
    end else if (cfg_we) begin
      last_index <= cfg_wdata;
    end
  end

  // Sequencer: accept, divide, read, swap, deliver
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step_position <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            // advance the run position as soon as the request is taken
            step_position <= (i_start == last_eff) ? '0 : i_start + POS_W'(1);
            state         <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == CW'(1)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_SWAP_I;
        end
        S_SWAP_I: begin
          state <= S_SWAP_J;
        end
        S_SWAP_J: begin
          // hold here while the previous result still waits
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers of the request at work
  always_ff @(posedge clk) begin
    if (accept) begin
      i_pos   <= i_start;
      last_r  <= last_eff;
      n_r     <= {1'b0, last_eff} - {1'b0, i_start} + (POS_W+1)'(1);
      rem     <= '0;
      word_sh <= s_tdata[WORD_BITS-1:0];
      cnt     <= CW'(WORD_BITS);
    end else if (state == S_DIV) begin
      rem     <= rem_next;
      word_sh <= word_sh << 1;
      cnt     <= cnt - CW'(1);
    end
    if (state == S_READ) begin
      f_i <= written[i_addr];
      f_j <= written[j_addr];
    end
    if (state == S_SWAP_I) begin
      vi_r <= vi;
    end
  end

  // Written flags: clear at run start, set on each swap write
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (accept && (i_start == '0)) begin
      written <= '0;
    end else if (mem_we) begin
      written[mem_waddr] <= 1'b1;
    end
  end

  // Permutation memory: two registered reads, one write
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      q_i <= perm_mem[i_addr];
      q_j <= perm_mem[j_addr];
    end
    if (mem_we) begin
      perm_mem[mem_waddr] <= mem_wdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Value fixed at i: entry j as read, before the swap.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos  <= i_pos;
      out_val  <= vj;
      out_last <= (i_pos == last_r);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_val, out_pos};
  assign m_tlast  = out_last;

  `RPS_ASSERT_IMP(a_rem_below_n, clk, rst, state == S_DIV, ({1'b0, rem} < n_r))
  `RPS_ASSERT_IMP(a_j_in_run, clk, rst, state == S_READ, (j_pos >= i_pos) && (j_pos <= last_r))
  `RPS_ASSERT_NXT(a_flag_i_set, clk, rst, state == S_SWAP_I, written[i_addr])

endmodule
